>>> rtl/stable_priority_queue_macros.svh
// Assertion macros for the stable priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTH
`define SPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("stable_priority_queue: assertion failed");
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stable_priority_queue: assertion failed");
`else
`define SPQ_ASSERT(lbl, prop)
`define SPQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/spq_pkg.sv
// Types, sizes and codes of the stable priority queue.
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int PRIO_BITS = 3;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef logic [1:0]           req_t;
  typedef logic [1:0]           status_t;
  typedef logic [3:0]           handle_t;
  typedef logic [7:0]           addr_t;
  typedef logic [15:0]          size_t;
  typedef logic [PRIO_BITS-1:0] prio_t;
  typedef logic [CNT_W-1:0]     count_t;

  localparam req_t REQ_INSERT = 2'd0;
  localparam req_t REQ_REMOVE = 2'd1;
  localparam req_t REQ_PEEK   = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_DUPLICATE = 2'd3;

  typedef struct packed {
    handle_t handle;
    addr_t   addr;
    size_t   size;
    prio_t   prio;
  } entry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // update the cell row and the result register
  } spq_cmd_t;

endpackage

>>> rtl/spq_ctrl.sv
// Sequencer of the stable priority queue: accept, execute, present result.
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output spq_pkg::spq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_RESP) && out_ready);
  assign out_valid = (state_r == S_RESP);
  assign accept    = in_valid && in_ready;

  assign cmd.load = accept;
  assign cmd.exec = (state_r == S_EXEC);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_nxt = accept ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/spq_dp.sv
// Cell row, request register and result register of the stable priority queue.
`include "stable_priority_queue_macros.svh"
module spq_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spq_pkg::spq_cmd_t    cmd,
  input  logic [1:0]           in_req_type,
  input  logic [3:0]           in_handle,
  input  logic [7:0]           in_entry_addr,
  input  logic [15:0]          in_entry_size,
  input  logic [2:0]           in_entry_priority,
  output logic [1:0]           out_status,
  output logic                 out_head_valid,
  output logic [3:0]           out_head_handle,
  output logic [7:0]           out_head_addr,
  output logic [15:0]          out_head_size,
  output logic [2:0]           out_head_priority,
  output logic [spq_pkg::CNT_W-1:0] out_occupancy
);

  localparam int D = spq_pkg::DEPTH;

  // Request register
  spq_pkg::req_t    req_r;
  spq_pkg::entry_t  new_r;

  // Cell row and fill count
  spq_pkg::entry_t  cell_r   [D];
  spq_pkg::entry_t  cell_nxt [D];
  spq_pkg::count_t  count_r;
  spq_pkg::count_t  count_nxt;
  spq_pkg::status_t status_nxt;

  // Result register
  spq_pkg::status_t status_r;
  logic             head_valid_r;
  spq_pkg::entry_t  head_r;
  spq_pkg::count_t  occ_r;

  logic [D-1:0] occ;
  logic [D-1:0] match;
  logic [D-1:0] ins_at;
  logic [D-1:0] rm_after;
  logic         found;
  logic         full;
  logic         insert_ok;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r       <= in_req_type;
      new_r       <= '{handle: in_handle, addr: in_entry_addr, size: in_entry_size,
                       prio: spq_pkg::prio_t'(in_entry_priority)};
    end
  end

  // Per-cell compares against the held request
  always_comb begin
    for (int i = 0; i < D; i++) begin
      occ[i]    = spq_pkg::count_t'(i) < count_r;
      match[i]  = occ[i] && (cell_r[i].handle == new_r.handle);
      // sorted row: free cells and lower-priority cells form a suffix
      ins_at[i] = !occ[i] || (cell_r[i].prio < new_r.prio);
      rm_after[i] = |(match & ({D{1'b1}} >> (D - 1 - i)));
    end
  end

  assign found = |match;
  assign full  = (count_r == spq_pkg::count_t'(D));

  // An insert that lands in the row this cycle
  assign insert_ok = cmd.exec && (req_r == spq_pkg::REQ_INSERT) && !found && !full;

  always_comb begin
    for (int i = 0; i < D; i++) cell_nxt[i] = cell_r[i];
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_OK;
    case (req_r)
      spq_pkg::REQ_INSERT: begin
        if (found) begin
          status_nxt = spq_pkg::ST_DUPLICATE;
        end else if (full) begin
          status_nxt = spq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + spq_pkg::count_t'(1);
          if (ins_at[0]) cell_nxt[0] = new_r;
          for (int i = 1; i < D; i++) begin
            if (ins_at[i]) cell_nxt[i] = ins_at[i-1] ? cell_r[i-1] : new_r;
          end
        end
      end
      spq_pkg::REQ_REMOVE: begin
        if (!found) begin
          status_nxt = spq_pkg::ST_NOT_FOUND;
        end else begin
          count_nxt = count_r - spq_pkg::count_t'(1);
          for (int i = 0; i < D - 1; i++) begin
            if (rm_after[i]) cell_nxt[i] = cell_r[i+1];
          end
        end
      end
      default: begin
        status_nxt = spq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < D; i++) cell_r[i] <= cell_nxt[i];
      status_r     <= status_nxt;
      head_valid_r <= (count_nxt != '0);
      head_r       <= (count_nxt != '0) ? cell_nxt[0] : '0;
      occ_r        <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign out_status        = status_r;
  assign out_head_valid    = head_valid_r;
  assign out_head_handle   = head_r.handle;
  assign out_head_addr     = head_r.addr;
  assign out_head_size     = head_r.size;
  assign out_head_priority = 3'(head_r.prio);
  assign out_occupancy     = occ_r;

  `SPQ_ASSERT(a_count_bound, count_r <= spq_pkg::count_t'(D))
  `SPQ_ASSERT_NEXT(a_count_hold, !cmd.exec, $stable(count_r))
  `SPQ_ASSERT_NEXT(a_insert_grows, insert_ok, count_r == $past(count_r) + spq_pkg::count_t'(1))

endmodule

>>> rtl/stable_priority_queue.sv
// Top level of the stable priority queue: controller plus cell-row datapath.
//
//   channel | ports                                   | direction | handshake
//   --------+-----------------------------------------+-----------+----------------------
//   request | in_req_type, in_handle, in_entry_*      | in        | in_valid / in_ready
//   result  | out_status, out_head_*, out_occupancy   | out       | out_valid / out_ready
//
// Sequence: an item is captured when it is accepted, then the cell row compares and
//   shifts in the execute state; the next item is taken in the cycle its predecessor's
//   result leaves, so a new item is not taken before the last result is taken.
// Reset: rst_n (synchronous, active low) empties the queue; no clearing pass is run.
// Stalls: while out_ready is low the result holds and no new item is taken.
module stable_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_handle,
  input  logic [7:0]  in_entry_addr,
  input  logic [15:0] in_entry_size,
  input  logic [2:0]  in_entry_priority,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_head_valid,
  output logic [3:0]  out_head_handle,
  output logic [7:0]  out_head_addr,
  output logic [15:0] out_head_size,
  output logic [2:0]  out_head_priority,
  output logic [spq_pkg::CNT_W-1:0] out_occupancy
);

  // Commands from the sequencer to the datapath
  spq_pkg::spq_cmd_t cmd;

  // Sequence each item: capture, execute, hold result until taken
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Hold entries sorted by priority, oldest first among equals; shift on
  // insert and remove, and register the head after each item
  spq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_req_type       (in_req_type),
    .in_handle         (in_handle),
    .in_entry_addr     (in_entry_addr),
    .in_entry_size     (in_entry_size),
    .in_entry_priority (in_entry_priority),
    .out_status        (out_status),
    .out_head_valid    (out_head_valid),
    .out_head_handle   (out_head_handle),
    .out_head_addr     (out_head_addr),
    .out_head_size     (out_head_size),
    .out_head_priority (out_head_priority),
    .out_occupancy     (out_occupancy)
  );

endmodule
